// ----- src/cbcp_pkg.sv -----
// Package for the configuration bitstream command parser.
// Holds request and result types, event codes, phase encoding, device tables and the CRC step.
// No dependencies.
`timescale 1ns / 1ps

package cbcp_pkg;

    // Request carried by the input channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_req_t;

    // Result carried by the result channel
    typedef struct packed {
        logic [4:0]  event_res;
        logic [7:0]  data_out;
        logic [13:0] frame_row;
        logic [7:0]  byte_position;
        logic [31:0] word_value;
        logic [2:0]  device_sel;
    } out_res_t;

    // Result event codes
    typedef enum logic [4:0] {
        EV_NONE       = 5'd0,
        EV_PREAMBLE   = 5'd1,
        EV_CRC_RESET  = 5'd2,
        EV_DEV_OK     = 5'd3,
        EV_DEV_BAD    = 5'd4,
        EV_CTRL       = 5'd5,
        EV_ADDR_RESET = 5'd6,
        EV_FRAME_BYTE = 5'd7,
        EV_CRC_OK     = 5'd8,
        EV_CRC_FAIL   = 5'd9,
        EV_FRAMES_END = 5'd10,
        EV_SED        = 5'd11,
        EV_SECURITY   = 5'd12,
        EV_USERCODE   = 5'd13,
        EV_DONE       = 5'd14,
        EV_BAD_CMD    = 5'd15,
        EV_IGNORED    = 5'd16,
        EV_OVERRUN    = 5'd17,
        EV_TRUNCATED  = 5'd18
    } event_t;

    // Parser phases, one-hot
    typedef enum logic [14:0] {
        PH_SEARCH   = 15'b000000000000001,
        PH_CMD      = 15'b000000000000010,
        PH_RSTCRC   = 15'b000000000000100,
        PH_VERIFY   = 15'b000000000001000,
        PH_CTRL     = 15'b000000000010000,
        PH_INITADDR = 15'b000000000100000,
        PH_PARAMS   = 15'b000000001000000,
        PH_FRAME    = 15'b000000010000000,
        PH_CRCHI    = 15'b000000100000000,
        PH_CRCLO    = 15'b000001000000000,
        PH_DUMMY    = 15'b000010000000000,
        PH_SED      = 15'b000100000000000,
        PH_SEC      = 15'b001000000000000,
        PH_USER     = 15'b010000000000000,
        PH_DONE     = 15'b100000000000000
    } phase_t;

    // Command bytes
    localparam logic [7:0] CMD_RSTCRC   = 8'h3B;
    localparam logic [7:0] CMD_VERIFY   = 8'hE2;
    localparam logic [7:0] CMD_CTRL     = 8'h22;
    localparam logic [7:0] CMD_INITADDR = 8'h46;
    localparam logic [7:0] CMD_PARAMS   = 8'h82;
    localparam logic [7:0] CMD_SED      = 8'hA2;
    localparam logic [7:0] CMD_SEC      = 8'hCE;
    localparam logic [7:0] CMD_USER     = 8'hC2;
    localparam logic [7:0] CMD_DONE     = 8'h5E;
    localparam logic [7:0] CMD_NOOP     = 8'hFF;

    localparam logic [15:0] CRC_POLY       = 16'h8005;
    localparam int          NUM_DEVICES    = 6;
    localparam logic [2:0]  DEFAULT_DEVICE = 3'd2;
    localparam logic [3:0]  DUMMY_MASK     = 4'hF;

    // Device ID, frame count and frame size tables
    function automatic logic [31:0] dev_id(input logic [2:0] i);
        case (i)
            3'd0:    dev_id = 32'h41111043;
            3'd1:    dev_id = 32'h41112043;
            3'd2:    dev_id = 32'h41113043;
            3'd3:    dev_id = 32'h01111043;
            3'd4:    dev_id = 32'h01112043;
            3'd5:    dev_id = 32'h01113043;
            default: dev_id = 32'h0;
        endcase
    endfunction

    function automatic logic [13:0] dev_frames(input logic [2:0] i);
        case (i)
            3'd0, 3'd3: dev_frames = 14'd7562;
            3'd1, 3'd4: dev_frames = 14'd9470;
            default:    dev_frames = 14'd13294;
        endcase
    endfunction

    function automatic logic [7:0] dev_frame_bytes(input logic [2:0] i);
        case (i)
            3'd0, 3'd3: dev_frame_bytes = 8'd74;
            3'd1, 3'd4: dev_frame_bytes = 8'd106;
            default:    dev_frame_bytes = 8'd142;
        endcase
    endfunction

    // Shift one byte into the augmented CRC, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] v);
        logic [15:0] c;
        logic        top;
        c = c_in;
        for (int i = 7; i >= 0; i--) begin
            top = c[15];
            c = {c[14:0], v[i]};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/cbcp_stream_if.sv -----
// Valid/ready stream interface with a generic payload type.
// Depends on nothing; used by the parser top level.
`timescale 1ns / 1ps

interface cbcp_stream_if #(parameter type payload_t = logic [7:0]) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/config_bitstream_command_parser.sv -----
// Top level of the configuration bitstream command parser.
// Depends on cbcp_pkg and cbcp_stream_if.
`timescale 1ns / 1ps
//
//  channel   direction  payload
//  in_s      sink       data_byte[8], end_of_stream[1]
//  out_s     source     event_res[5], data_out[8], frame_row[14], byte_position[8],
//                       word_value[32], device_sel[3]
//
// Each request is parsed in the cycle it is accepted; its result is registered and
// shown the next cycle. One request per cycle while out_s takes results; the parser
// state updates once per accepted request. in_s.ready is high whenever the result
// register is empty or being taken, so an output stall stops input one for one. Reset
// (rst_n, async low) returns to preamble search with device two selected.

module config_bitstream_command_parser (
    input logic clk,
    input logic rst_n,
    cbcp_stream_if.sink   in_s,
    cbcp_stream_if.source out_s
);
    import cbcp_pkg::*;

    localparam logic [63:0] PREAMBLE = 64'hFFFFBDB3FFFFFFFF;

    phase_t      phase_reg, phase_next;
    logic [63:0] win_reg, win_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] opw_reg, opw_next;
    logic [3:0]  dummy_reg, dummy_next;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] fnum_reg, fnum_next;
    logic [7:0]  fidx_reg, fidx_next;
    logic [7:0]  exph_reg, exph_next;
    logic [2:0]  dev_reg, dev_next;
    logic        halt_reg, halt_next;

    logic        ovalid_reg;
    logic [4:0]  ev_reg;
    logic [7:0]  dout_reg;
    logic [13:0] row_reg;
    logic [7:0]  pos_reg;
    logic [31:0] word_reg;
    logic [2:0]  sel_reg;

    event_t      ev;
    logic [7:0]  dout, pos;
    logic [13:0] row;
    logic [31:0] word;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] crc_b;
    logic [15:0] crc_fin;
    logic [2:0]  d;
    logic [7:0]  dec;
    logic [15:0] frames_full;
    logic [7:0]  fidx_inc;
    logic [15:0] fnum_inc;
    logic [31:0] opw_shift;
    logic        id_hit;
    logic [2:0]  id_sel;

    assign in_s.ready = !ovalid_reg || out_s.ready;
    assign accept     = in_s.valid && in_s.ready;
    assign b          = in_s.payload.data_byte;
    assign d          = (dev_reg < 3'(NUM_DEVICES)) ? dev_reg : DEFAULT_DEVICE;
    assign crc_b      = crc_byte(crc_reg, b);
    assign crc_fin    = crc_byte(crc_byte(crc_reg, 8'h00), 8'h00);
    assign dec        = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
    assign frames_full = {freq_reg[15:8], b};
    assign fidx_inc   = fidx_reg + 8'd1;
    assign fnum_inc   = fnum_reg + 16'd1;
    assign opw_shift  = {opw_reg[23:0], b};

    // Device ID lookup on the operand word completed by this byte
    always_comb
    begin
        id_hit = 1'b0;
        id_sel = 3'd0;
        for (int i = NUM_DEVICES - 1; i >= 0; i--) begin
            if (dev_id(3'(i)) == opw_shift)
            begin
                id_hit = 1'b1;
                id_sel = 3'(i);
            end
        end
    end

    // Parser next state
    always_comb
    begin
        phase_next = phase_reg;
        win_next   = win_reg;
        crc_next   = crc_reg;
        left_next  = left_reg;
        opw_next   = opw_reg;
        dummy_next = dummy_reg;
        freq_next  = freq_reg;
        fnum_next  = fnum_reg;
        fidx_next  = fidx_reg;
        exph_next  = exph_reg;
        dev_next   = dev_reg;
        halt_next  = halt_reg;
        ev   = EV_NONE;
        dout = 8'd0;
        row  = 14'd0;
        pos  = 8'd0;
        word = 32'd0;

        if (halt_reg)
        begin
            ev = EV_IGNORED;
        end
        else
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    win_next = {win_reg[55:0], b};
                    if (win_next == PREAMBLE)
                    begin
                        ev = EV_PREAMBLE;
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    crc_next = crc_b;
                    opw_next = 32'd0;
                    unique case (b)
                        CMD_RSTCRC:   begin phase_next = PH_RSTCRC;   left_next = 8'd3; end
                        CMD_VERIFY:   begin phase_next = PH_VERIFY;   left_next = 8'd7; end
                        CMD_CTRL:     begin phase_next = PH_CTRL;     left_next = 8'd7; end
                        CMD_INITADDR: begin phase_next = PH_INITADDR; left_next = 8'd3; end
                        CMD_PARAMS:   begin phase_next = PH_PARAMS;   left_next = 8'd3; end
                        CMD_SED:      begin phase_next = PH_SED;      left_next = 8'd7; end
                        CMD_SEC:      begin phase_next = PH_SEC;      left_next = 8'd3; end
                        CMD_USER:     begin phase_next = PH_USER;     left_next = 8'd9; end
                        CMD_DONE:     begin phase_next = PH_DONE;     left_next = 8'd3; end
                        CMD_NOOP:     begin end
                        default:
                        begin
                            ev = EV_BAD_CMD;
                            word = {24'd0, b};
                            halt_next = 1'b1;
                        end
                    endcase
                end
                PH_PARAMS:
                begin
                    crc_next = crc_b;
                    if (left_reg >= 8'd3)
                    begin
                        dummy_next = b[3:0] & DUMMY_MASK;
                        left_next = 8'd2;
                    end
                    else if (left_reg == 8'd2)
                    begin
                        freq_next = {b, freq_reg[7:0]};
                        left_next = 8'd1;
                    end
                    else
                    begin
                        freq_next = frames_full;
                        left_next = 8'd0;
                        fnum_next = 16'd0;
                        fidx_next = 8'd0;
                        if (frames_full > {2'b00, dev_frames(d)})
                        begin
                            ev = EV_OVERRUN;
                            halt_next = 1'b1;
                        end
                        else if (frames_full == 16'd0)
                        begin
                            crc_next = 16'd0;
                            ev = EV_FRAMES_END;
                            phase_next = PH_CMD;
                        end
                        else
                        begin
                            phase_next = PH_FRAME;
                        end
                    end
                end
                PH_FRAME:
                begin
                    crc_next = crc_b;
                    ev = EV_FRAME_BYTE;
                    dout = b;
                    row = dev_frames(d) - 14'd1 - fnum_reg[13:0];
                    pos = fidx_reg;
                    fidx_next = fidx_inc;
                    if (fidx_inc >= dev_frame_bytes(d))
                    begin
                        phase_next = PH_CRCHI;
                    end
                end
                PH_CRCHI:
                begin
                    exph_next = b;
                    phase_next = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    crc_next = 16'd0;
                    ev = (crc_fin == {exph_reg, b}) ? EV_CRC_OK : EV_CRC_FAIL;
                    word = {16'd0, crc_fin};
                    if (dummy_reg != 4'd0)
                    begin
                        left_next = {4'd0, dummy_reg};
                        phase_next = PH_DUMMY;
                    end
                    else
                    begin
                        fnum_next = fnum_inc;
                        fidx_next = 8'd0;
                        phase_next = (fnum_inc >= freq_reg) ? PH_CMD : PH_FRAME;
                    end
                end
                PH_DUMMY:
                begin
                    crc_next = crc_b;
                    left_next = dec;
                    if (dec == 8'd0)
                    begin
                        fnum_next = fnum_inc;
                        fidx_next = 8'd0;
                        if (fnum_inc >= freq_reg)
                        begin
                            crc_next = 16'd0;
                            ev = EV_FRAMES_END;
                            phase_next = PH_CMD;
                        end
                        else
                        begin
                            phase_next = PH_FRAME;
                        end
                    end
                end
                default:
                begin
                    // Fixed-length commands
                    crc_next = crc_b;
                    if ((((phase_reg == PH_VERIFY) || (phase_reg == PH_CTRL))
                            && left_reg <= 8'd4)
                        || (phase_reg == PH_USER && left_reg >= 8'd3 && left_reg <= 8'd6))
                    begin
                        opw_next = opw_shift;
                    end
                    left_next = dec;
                    if (dec == 8'd0)
                    begin
                        phase_next = PH_CMD;
                        case (phase_reg)
                            PH_RSTCRC:   begin crc_next = 16'd0; ev = EV_CRC_RESET; end
                            PH_VERIFY:
                            begin
                                word = opw_next;
                                if (id_hit)
                                begin
                                    ev = EV_DEV_OK;
                                    dev_next = id_sel;
                                end
                                else
                                begin
                                    ev = EV_DEV_BAD;
                                    halt_next = 1'b1;
                                end
                            end
                            PH_CTRL:     begin ev = EV_CTRL; word = opw_next; end
                            PH_INITADDR: ev = EV_ADDR_RESET;
                            PH_SED:      ev = EV_SED;
                            PH_SEC:      ev = EV_SECURITY;
                            PH_USER:     begin ev = EV_USERCODE; word = opw_next; end
                            default:     ev = EV_DONE;
                        endcase
                    end
                end
            endcase
            if (in_s.payload.end_of_stream)
            begin
                if (!halt_next && phase_next != PH_CMD)
                begin
                    ev = EV_TRUNCATED;
                    dout = 8'd0;
                    row = 14'd0;
                    pos = 8'd0;
                    word = 32'd0;
                end
                halt_next = 1'b1;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            win_reg   <= 64'd0;
            crc_reg   <= 16'd0;
            left_reg  <= 8'd0;
            opw_reg   <= 32'd0;
            dummy_reg <= 4'd0;
            freq_reg  <= 16'd0;
            fnum_reg  <= 16'd0;
            fidx_reg  <= 8'd0;
            exph_reg  <= 8'd0;
            dev_reg   <= DEFAULT_DEVICE;
            halt_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            opw_reg   <= opw_next;
            dummy_reg <= dummy_next;
            freq_reg  <= freq_next;
            fnum_reg  <= fnum_next;
            fidx_reg  <= fidx_next;
            exph_reg  <= exph_next;
            dev_reg   <= dev_next;
            halt_reg  <= halt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (in_s.ready)
        begin
            ovalid_reg <= in_s.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg   <= ev;
            dout_reg <= dout;
            row_reg  <= row;
            pos_reg  <= pos;
            word_reg <= word;
            sel_reg  <= dev_next;
        end
    end

    assign out_s.valid                 = ovalid_reg;
    assign out_s.payload.event_res     = ev_reg;
    assign out_s.payload.data_out      = dout_reg;
    assign out_s.payload.frame_row     = row_reg;
    assign out_s.payload.byte_position = pos_reg;
    assign out_s.payload.word_value    = word_reg;
    assign out_s.payload.device_sel    = sel_reg;

endmodule
